### sv/srpc_pkg.sv
// Shared types, codes and constants for the servo reply packet checker.
`timescale 1ns / 1ps

package srpc_pkg;

  localparam int MAX_PARAMS_DEF = 32;
  localparam int STORE_DEPTH    = 32;
  localparam int STORE_AW       = $clog2(STORE_DEPTH);
  localparam int CNT_W          = 6;
  localparam int ELAPSED_W      = 18;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] BCAST_ID  = 8'hFE;
  localparam logic [7:0] ERR_MASK  = 8'h7F;

  localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(STORE_DEPTH);

  // input kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_EXPECTED_ID   = 2'd0;
  localparam logic [1:0] REG_RESP_CAPACITY = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_MS    = 2'd2;

  localparam logic [7:0]       EXPECTED_ID_RST   = 8'd1;
  localparam logic [CNT_W-1:0] RESP_CAPACITY_RST = 6'd8;
  localparam logic [15:0]      TIMEOUT_MS_RST    = 16'd20;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_BAD_ID     = 3'd2,
    ST_BAD_LENGTH = 3'd3,
    ST_SERVO_ERR  = 3'd4,
    ST_CHECKSUM   = 3'd5,
    ST_TIMEOUT    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_READ,
    EM_SEND
  } emit_state_t;

  // frame outcome handed from the parser to the emitter
  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [CNT_W-1:0] count;
    logic [7:0]       servo_error;
  } fin_t;

endpackage

### sv/srpc_store.sv
// Parameter byte memory: one write port, one registered read port.
`timescale 1ns / 1ps

module srpc_store (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [srpc_pkg::STORE_AW-1:0] wr_addr,
  input  logic [7:0]                    wr_data,
  input  logic                          rd_en,
  input  logic [srpc_pkg::STORE_AW-1:0] rd_addr,
  output logic [7:0]                    rd_data
);
  import srpc_pkg::*;

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/srpc_parser.sv
// Frame parser: header and body checks, checksum, timeouts, parameter writes.
`timescale 1ns / 1ps

module srpc_parser #(
  parameter int MAX_PARAMS = srpc_pkg::MAX_PARAMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [1:0]                    kind,
  input  logic [7:0]                    rx_byte,
  input  logic [7:0]                    expected_id,
  input  logic [srpc_pkg::CNT_W-1:0]    resp_capacity,
  input  logic [15:0]                   timeout_ms,
  output srpc_pkg::fin_t                fin,
  output logic                          wr_en,
  output logic [srpc_pkg::STORE_AW-1:0] wr_addr,
  output logic [7:0]                    wr_data
);
  import srpc_pkg::*;

  localparam int LW = $clog2(MAX_PARAMS + 3);   // holds the length byte
  localparam int BW = $clog2(MAX_PARAMS + 2);   // holds the body position
  localparam int CW = (LW > CNT_W) ? LW : CNT_W;
  localparam int IW = BW + STORE_AW;
  localparam logic [8:0] LEN_MAX = 9'(MAX_PARAMS + 2);

  phase_t                 phase, phase_next;
  logic [1:0]             header_count;
  logic [LW-1:0]          reply_length;
  logic [7:0]             error_byte;
  logic [7:0]             running_sum;
  logic [BW-1:0]          body_count;
  logic [ELAPSED_W-1:0]   elapsed_ms;

  logic [ELAPSED_W-1:0]   limit, elapsed_inc;
  logic                   tick_fail;
  logic                   is_byte, is_tick;
  logic                   hdr_fail;
  status_t                hdr_code;
  logic [LW-1:0]          pcount;
  logic                   is_err_byte, is_param, is_csum;
  logic                   err_fail, csum_fail;
  logic [CW-1:0]          pcount_x, cap_x, n_x;
  logic [CNT_W-1:0]       cap;
  logic [IW-1:0]          idx_wide;
  logic                   in_store;

  // shared decode
  always_comb begin
    is_byte = accept && (kind == KIND_BYTE);
    is_tick = accept && (kind == KIND_TICK);

    limit = (phase == PH_HEADER) ? ELAPSED_W'(timeout_ms)
                                 : ELAPSED_W'({timeout_ms, 1'b0}) + ELAPSED_W'(timeout_ms);
    elapsed_inc = (elapsed_ms == ELAPSED_MAX) ? elapsed_ms : elapsed_ms + 1'b1;
    tick_fail = elapsed_inc > limit;

    hdr_fail = 1'b0;
    hdr_code = ST_BAD_HEADER;
    if (header_count < 2'd2) begin
      hdr_fail = (rx_byte != SYNC_BYTE);
      hdr_code = ST_BAD_HEADER;
    end else if (header_count == 2'd2) begin
      hdr_fail = (rx_byte != expected_id) && (rx_byte != BCAST_ID);
      hdr_code = ST_BAD_ID;
    end else begin
      hdr_fail = (rx_byte < 8'd2) || ({1'b0, rx_byte} > LEN_MAX);
      hdr_code = ST_BAD_LENGTH;
    end

    pcount      = reply_length - LW'(2);
    is_err_byte = (body_count == '0);
    is_param    = !is_err_byte && (LW'(body_count) <= pcount);
    is_csum     = !is_err_byte && !is_param;
    err_fail    = (rx_byte & ERR_MASK) != 8'd0;
    csum_fail   = (~running_sum) != rx_byte;

    cap      = (resp_capacity > CAP_MAX) ? CAP_MAX : resp_capacity;
    pcount_x = CW'(pcount);
    cap_x    = CW'(cap);
    n_x      = (pcount_x < cap_x) ? pcount_x : cap_x;

    idx_wide = IW'(body_count) - IW'(1);
    in_store = (idx_wide >> STORE_AW) == '0;
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      case (kind)
        KIND_START: phase_next = PH_HEADER;
        KIND_TICK: begin
          if (phase != PH_IDLE && tick_fail) phase_next = PH_IDLE;
        end
        KIND_BYTE: begin
          if (phase == PH_HEADER) begin
            if (hdr_fail) phase_next = PH_IDLE;
            else if (header_count == 2'd3) phase_next = PH_BODY;
          end else if (phase == PH_BODY) begin
            if ((is_err_byte && err_fail) || is_csum) phase_next = PH_IDLE;
          end
        end
        default: phase_next = phase;
      endcase
    end
  end

  // frame outcome and memory write
  always_comb begin
    fin             = '0;
    fin.status      = ST_OK;
    fin.servo_error = error_byte;
    if (is_tick && phase != PH_IDLE && tick_fail) begin
      fin.valid  = 1'b1;
      fin.status = ST_TIMEOUT;
    end else if (is_byte && phase == PH_HEADER && hdr_fail) begin
      fin.valid  = 1'b1;
      fin.status = hdr_code;
    end else if (is_byte && phase == PH_BODY && is_err_byte && err_fail) begin
      fin.valid       = 1'b1;
      fin.status      = ST_SERVO_ERR;
      fin.servo_error = rx_byte;
    end else if (is_byte && phase == PH_BODY && is_csum) begin
      fin.valid  = 1'b1;
      fin.status = csum_fail ? ST_CHECKSUM : ST_OK;
      fin.count  = csum_fail ? '0 : CNT_W'(n_x);
    end

    wr_en   = is_byte && (phase == PH_BODY) && is_param && in_store;
    wr_addr = idx_wide[STORE_AW-1:0];
    wr_data = rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      header_count <= '0;
      reply_length <= '0;
      error_byte   <= '0;
      running_sum  <= '0;
      body_count   <= '0;
      elapsed_ms   <= '0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        case (kind)
          KIND_START: begin
            header_count <= '0;
            reply_length <= '0;
            error_byte   <= '0;
            running_sum  <= '0;
            body_count   <= '0;
            elapsed_ms   <= '0;
          end
          KIND_TICK: begin
            if (phase != PH_IDLE) elapsed_ms <= elapsed_inc;
          end
          KIND_BYTE: begin
            if (phase == PH_HEADER && !hdr_fail) begin
              if (header_count == 2'd3) begin
                reply_length <= LW'(rx_byte);
                running_sum  <= expected_id + rx_byte;
                body_count   <= '0;
              end else begin
                header_count <= header_count + 2'd1;
              end
            end else if (phase == PH_BODY) begin
              if (is_err_byte) begin
                error_byte <= rx_byte;
                if (!err_fail) begin
                  running_sum <= running_sum + rx_byte;
                  body_count  <= BW'(1);
                end
              end else if (is_param) begin
                running_sum <= running_sum + rx_byte;
                body_count  <= body_count + BW'(1);
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

### sv/srpc_emit.sv
// Result emitter: status item or parameter burst read from the store.
`timescale 1ns / 1ps

module srpc_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  srpc_pkg::fin_t                fin,
  output logic                          idle,
  output logic                          rd_en,
  output logic [srpc_pkg::STORE_AW-1:0] rd_addr,
  input  logic [7:0]                    rd_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic [7:0]                    data,
  output logic                          data_valid,
  output logic                          last,
  output logic [srpc_pkg::CNT_W-1:0]    param_count,
  output logic [7:0]                    servo_error
);
  import srpc_pkg::*;

  emit_state_t      state, state_next;
  status_t          st;
  logic [CNT_W-1:0] count;
  logic [7:0]       serr;
  logic [CNT_W-1:0] idx, idx_inc;
  logic             with_data;
  logic             xfer;

  always_comb begin
    idx_inc = idx + CNT_W'(1);
    xfer    = out_valid && out_ready;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      EM_IDLE: begin
        if (fin.valid) begin
          state_next = (fin.status == ST_OK && fin.count != '0) ? EM_READ : EM_SEND;
        end
      end
      EM_READ: state_next = EM_SEND;
      EM_SEND: begin
        if (xfer && last) state_next = EM_IDLE;
      end
      default: state_next = EM_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    idle        = (state == EM_IDLE);
    out_valid   = (state == EM_SEND);
    status      = st;
    data_valid  = with_data;
    data        = with_data ? rd_data : 8'd0;
    last        = !with_data || (idx_inc == count);
    param_count = with_data ? count : '0;
    servo_error = serr;
    rd_en       = 1'b0;
    rd_addr     = idx[STORE_AW-1:0];
    case (state)
      EM_READ: rd_en = 1'b1;
      EM_SEND: begin
        // fetch the next byte while the current one transfers
        if (xfer && !last) begin
          rd_en   = 1'b1;
          rd_addr = idx_inc[STORE_AW-1:0];
        end
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == EM_IDLE && fin.valid) begin
      st        <= fin.status;
      count     <= fin.count;
      serr      <= fin.servo_error;
      idx       <= '0;
      with_data <= (fin.status == ST_OK) && (fin.count != '0);
    end else if (state == EM_SEND && xfer) begin
      idx <= idx_inc;
    end
  end

endmodule

### sv/servo_reply_packet_checker.sv
// Top level of the servo reply packet checker.
`timescale 1ns / 1ps
// Output: a status-only result is valid in the cycle after the transfer that ends the frame;
//   a parameter burst passes the read state first, then one byte per cycle while out_ready
//   is high. Throughput: one input item per cycle while no result is pending; input ready
//   stays low from the frame-ending transfer until the last result transfers (emitter busy).
// Reset: synchronous, active high; registers return to id 1, capacity 8, timeout 20 ms, parser
//   idle. The parameter memory is not cleared; every frame writes it before reading it.

module servo_reply_packet_checker #(
  parameter int MAX_PARAMS = srpc_pkg::MAX_PARAMS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // input item channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 kind,
  input  logic [7:0]                 rx_byte,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 status,
  output logic [7:0]                 data,
  output logic                       data_valid,
  output logic                       last,
  output logic [srpc_pkg::CNT_W-1:0] param_count,
  output logic [7:0]                 servo_error,
  // configuration write port
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [15:0]                cfg_data
);
  import srpc_pkg::*;

  logic [7:0]           expected_id;
  logic [CNT_W-1:0]     resp_capacity;
  logic [15:0]          timeout_ms;

  logic                 in_xfer;
  logic                 emit_idle;
  fin_t                 fin;
  logic                 wr_en, rd_en;
  logic [STORE_AW-1:0]  wr_addr, rd_addr;
  logic [7:0]           wr_data, rd_data;

  // Configuration registers: written by index, no read-back. Unknown indexes drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id   <= EXPECTED_ID_RST;
      resp_capacity <= RESP_CAPACITY_RST;
      timeout_ms    <= TIMEOUT_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EXPECTED_ID:   expected_id   <= cfg_data[7:0];
        REG_RESP_CAPACITY: resp_capacity <= cfg_data[CNT_W-1:0];
        REG_TIMEOUT_MS:    timeout_ms    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Hold off input while a result is pending. This also keeps parser writes away
  // from the store while the emitter reads it, so no forwarding is needed.
  assign in_ready = emit_idle;
  assign in_xfer  = in_valid && in_ready;

  // Parser: one item per transfer, writes parameter bytes, reports the frame outcome.
  srpc_parser #(
    .MAX_PARAMS(MAX_PARAMS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_xfer),
    .kind         (kind),
    .rx_byte      (rx_byte),
    .expected_id  (expected_id),
    .resp_capacity(resp_capacity),
    .timeout_ms   (timeout_ms),
    .fin          (fin),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  // Parameter memory with a registered read port.
  srpc_store u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Emitter: latch the outcome, then hand out a status item or the byte burst.
  srpc_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .fin        (fin),
    .idle       (emit_idle),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .data       (data),
    .data_valid (data_valid),
    .last       (last),
    .param_count(param_count),
    .servo_error(servo_error)
  );

  // Input and output never both open: the interlock that guards the store.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input open while a result is pending");

  // A parameter byte only comes from a good frame with a nonzero count.
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && data_valid) |-> (status == ST_OK && param_count != '0))
    else $error("parameter byte outside a good frame");

  // The final transfer of a reply closes the output channel.
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> !out_valid)
    else $error("output still valid after last transfer");

  // A status-only reply starts only after a frame-ending input transfer.
  a_start_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && !data_valid |-> $past(in_xfer))
    else $error("status item without a frame-ending transfer");

endmodule
